// ----- rtl/core/markov_transition_count_sampler_defines.svh -----
// Assertion macros shared by the sampler RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef MARKOV_TRANSITION_COUNT_SAMPLER_DEFINES_SVH
`define MARKOV_TRANSITION_COUNT_SAMPLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MTCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MTCS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define MTCS_ASSERT(lbl, prop, msg)
`define MTCS_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- rtl/core/mtcs_pkg.sv -----
`default_nettype none

package mtcs_pkg;

  localparam int NUM_STATES = 256;
  localparam int MAX_SUCC   = 16;

  localparam int ID_W   = 8;
  localparam int CNT_W  = 16;
  localparam int RND_W  = 16;
  localparam int ROW_W  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int IDX_W  = (MAX_SUCC > 1) ? $clog2(MAX_SUCC) : 1;
  localparam int LEN_W  = $clog2(MAX_SUCC + 1);
  localparam int ENT_W  = ID_W + CNT_W;
  localparam int ROWM_W = LEN_W + CNT_W;
  localparam int ENT_DEPTH = NUM_STATES * (2 ** IDX_W);
  localparam int ENT_AW    = $clog2(ENT_DEPTH);

  // Row ids need a true modulo only for a small, non power of two table.
  localparam bit ROW_NEEDS_MOD =
    (NUM_STATES < 256) && ((NUM_STATES & (NUM_STATES - 1)) != 0);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int MOD_W     = 16;
  localparam int MOD_CNT_W = $clog2(MOD_W);

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_SAT   = 2'd2;
  localparam status_t STAT_EMPTY = 2'd3;

  typedef enum logic {
    OP_LEARN  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMOD,
    ST_ROW_RD,
    ST_ROW_CHK,
    ST_E_RD,
    ST_E_CHK,
    ST_APPEND,
    ST_SMOD,
    ST_S_RD,
    ST_S_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] dividend;
    logic [MOD_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] remainder;
  } mod_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/mtcs_ram.sv -----
`default_nettype none

module mtcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/mtcs_mod_unit.sv -----
`default_nettype none
`include "markov_transition_count_sampler_defines.svh"

module mtcs_mod_unit
  import mtcs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mod_req_t req,
  output mod_rsp_t      rsp
);

  logic                 busy;
  logic                 done;
  logic [MOD_CNT_W-1:0] cnt;
  logic [MOD_W-1:0]     rem;
  logic [MOD_W-1:0]     dvd;
  logic [MOD_W-1:0]     dsr;
  logic [MOD_W:0]       trial;
  logic [MOD_W:0]       diff;
  logic                 fits;
  logic                 last_step;

  // Restoring remainder, one dividend bit per cycle.
  assign trial     = {rem, dvd[MOD_W-1]};
  assign diff      = trial - {1'b0, dsr};
  assign fits      = trial >= {1'b0, dsr};
  assign last_step = cnt == MOD_CNT_W'(MOD_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= MOD_CNT_W'(cnt + 1'b1);
        if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
      dvd <= {dvd[MOD_W-2:0], 1'b0};
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

  `MTCS_ASSERT(a_start_idle, req.start |-> !busy, "mod unit restarted while busy")
  `MTCS_ASSERT_NEXT(a_done_after_last, busy && last_step, done, "mod unit missed done")
  `MTCS_ASSERT(a_rem_below_dsr, done |-> (rem < dsr), "remainder not below divisor")

endmodule

`default_nettype wire

// ----- rtl/core/markov_transition_count_sampler.sv -----
// Learn scans the row's successors in turn; sample first draws through the bit-serial
// modulo, then walks the row; an empty row answers a sample without a walk.
// Throughput: one item at a time; the next beat is taken once this result is staged.
// Reset: synchronous; afterwards all NUM_STATES (256) row table entries are swept
// clear with in_ready low. Successor entries are not cleared.
`default_nettype none
`include "markov_transition_count_sampler_defines.svh"

module markov_transition_count_sampler
  import mtcs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             operation,
  input  wire logic [ID_W-1:0]  from_state,
  input  wire logic [ID_W-1:0]  to_state,
  input  wire logic [RND_W-1:0] random_value,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [ID_W-1:0]  next_state,
  output status_t               status
);

  state_t state;
  state_t state_next;

  // Item registers.
  op_t              op;
  logic [ROW_W-1:0] row;
  logic [ID_W-1:0]  succ;
  logic [RND_W-1:0] rnd;

  // Row snapshot and walk state.
  logic [LEN_W-1:0] len;
  logic [CNT_W-1:0] total;
  logic [LEN_W-1:0] idx;
  logic [CNT_W-1:0] acc;
  logic [CNT_W-1:0] rem_val;
  logic [ROW_W-1:0] clr_cnt;

  // Staged result.
  logic [ID_W-1:0] res_next;
  status_t         res_status;

  // Memory ports.
  logic              row_we;
  logic [ROW_W-1:0]  row_addr;
  logic [ROWM_W-1:0] row_wdata;
  logic [ROWM_W-1:0] row_rdata;
  logic              ent_we;
  logic [ENT_AW-1:0] ent_addr;
  logic [ENT_W-1:0]  ent_wdata;
  logic [ENT_W-1:0]  ent_rdata;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  // Decoded read data and compares.
  logic [LEN_W-1:0] row_len_rd;
  logic [CNT_W-1:0] row_tot_rd;
  logic [ID_W-1:0]  ent_id;
  logic [CNT_W-1:0] ent_cnt;
  logic [CNT_W-1:0] acc_sum;
  logic             last_entry;
  logic             hit;
  logic             sat_hit;
  logic             row_full;
  logic             row_empty;
  logic             out_free;

  // Row table: length and running total per state, swept clear after reset.
  mtcs_ram #(
    .WIDTH (ROWM_W),
    .DEPTH (NUM_STATES)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .addr  (row_addr),
    .wdata (row_wdata),
    .rdata (row_rdata)
  );

  // Successor table: id and count, addressed by row and slot.
  mtcs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENT_DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .addr  (ent_addr),
    .wdata (ent_wdata),
    .rdata (ent_rdata)
  );

  // Shared modulo unit: row reduction when needed and the sample draw.
  mtcs_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  assign row_len_rd = row_rdata[ROWM_W-1:CNT_W];
  assign row_tot_rd = row_rdata[CNT_W-1:0];
  assign ent_id     = ent_rdata[ENT_W-1:CNT_W];
  assign ent_cnt    = ent_rdata[CNT_W-1:0];
  assign ent_addr   = {row, idx[IDX_W-1:0]};
  assign acc_sum    = CNT_W'(acc + ent_cnt);
  assign last_entry = idx == LEN_W'(len - 1'b1);
  assign hit        = ent_id == succ;
  assign sat_hit    = (total == CNT_MAX) || (ent_cnt == CNT_MAX);
  assign row_full   = len >= LEN_W'(MAX_SUCC);
  assign row_empty  = (row_tot_rd == '0) || (row_len_rd == '0);
  assign out_free   = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == ROW_W'(NUM_STATES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ROW_NEEDS_MOD ? ST_RMOD : ST_ROW_RD;
        end
      end
      ST_RMOD: begin
        if (mod_rsp.done) begin
          state_next = ST_ROW_RD;
        end
      end
      ST_ROW_RD: state_next = ST_ROW_CHK;
      ST_ROW_CHK: begin
        if (op == OP_LEARN) begin
          state_next = (row_len_rd == '0) ? ST_APPEND : ST_E_RD;
        end else begin
          state_next = row_empty ? ST_DONE : ST_SMOD;
        end
      end
      ST_E_RD: state_next = ST_E_CHK;
      ST_E_CHK: begin
        if (hit) begin
          state_next = ST_DONE;
        end else if (last_entry) begin
          state_next = ST_APPEND;
        end else begin
          state_next = ST_E_RD;
        end
      end
      ST_APPEND: state_next = ST_DONE;
      ST_SMOD: begin
        if (mod_rsp.done) begin
          state_next = ST_S_RD;
        end
      end
      ST_S_RD: state_next = ST_S_CHK;
      ST_S_CHK: begin
        if ((rem_val < acc_sum) || last_entry) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_S_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs: handshake, memory writes, modulo requests.
  always_comb begin
    in_ready         = 1'b0;
    row_we           = 1'b0;
    row_addr         = row;
    row_wdata        = {LEN_W'(len + 1'b1), CNT_W'(total + 1'b1)};
    ent_we           = 1'b0;
    ent_wdata        = {succ, CNT_W'(1)};
    mod_req.start    = 1'b0;
    mod_req.dividend = MOD_W'(rnd);
    mod_req.divisor  = MOD_W'(row_tot_rd);
    case (state)
      ST_CLEAR: begin
        row_we    = 1'b1;
        row_addr  = clr_cnt;
        row_wdata = '0;
      end
      ST_IDLE: begin
        in_ready         = 1'b1;
        mod_req.start    = in_valid && ROW_NEEDS_MOD;
        mod_req.dividend = MOD_W'(from_state);
        mod_req.divisor  = MOD_W'(NUM_STATES);
      end
      ST_ROW_CHK: begin
        mod_req.start = (op == OP_SAMPLE) && !row_empty;
      end
      ST_E_CHK: begin
        // Bump an existing successor and the row total.
        if (hit && !sat_hit) begin
          ent_we    = 1'b1;
          ent_wdata = {ent_id, CNT_W'(ent_cnt + 1'b1)};
          row_we    = 1'b1;
          row_wdata = {len, CNT_W'(total + 1'b1)};
        end
      end
      ST_APPEND: begin
        // Append a new successor with count one at slot len.
        if (!row_full && (total != CNT_MAX)) begin
          ent_we = 1'b1;
          row_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= ROW_W'(clr_cnt + 1'b1);
      end
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op   <= op_t'(operation);
          row  <= ROW_W'(from_state);
          succ <= to_state;
          rnd  <= random_value;
        end
      end
      ST_RMOD: begin
        if (mod_rsp.done) begin
          row <= ROW_W'(mod_rsp.remainder);
        end
      end
      ST_ROW_CHK: begin
        len        <= row_len_rd;
        total      <= row_tot_rd;
        idx        <= '0;
        acc        <= '0;
        // Holds only if the row turns out empty; otherwise overwritten.
        res_next   <= '0;
        res_status <= STAT_EMPTY;
      end
      ST_E_CHK: begin
        if (hit) begin
          res_next   <= succ;
          res_status <= sat_hit ? STAT_SAT : STAT_OK;
        end else begin
          idx <= LEN_W'(idx + 1'b1);
        end
      end
      ST_APPEND: begin
        res_next <= succ;
        if (row_full) begin
          res_status <= STAT_FULL;
        end else if (total == CNT_MAX) begin
          res_status <= STAT_SAT;
        end else begin
          res_status <= STAT_OK;
        end
      end
      ST_SMOD: begin
        if (mod_rsp.done) begin
          rem_val <= CNT_W'(mod_rsp.remainder);
        end
      end
      ST_S_CHK: begin
        // Advance the cumulative walk; the last pick taken stands.
        acc        <= acc_sum;
        idx        <= LEN_W'(idx + 1'b1);
        res_next   <= ent_id;
        res_status <= STAT_OK;
      end
      ST_DONE: begin
        if (out_free) begin
          next_state <= res_next;
          status     <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  `MTCS_ASSERT(a_walk_in_row, ((state == ST_E_CHK) || (state == ST_S_CHK)) |-> (idx < len), "walk past row length")
  `MTCS_ASSERT(a_draw_below_total, (state == ST_S_RD) |-> (rem_val < total), "draw not below row total")
  `MTCS_ASSERT(a_walk_covers_draw, ((state == ST_S_CHK) && last_entry) |-> (rem_val < acc_sum), "row counts do not sum to total")

endmodule

`default_nettype wire
